@@ rtl/gamma_run_window_decoder_defines.svh @@
// assertion macros for the gamma run window decoder
`ifndef GAMMA_RUN_WINDOW_DECODER_DEFINES_SVH
`define GAMMA_RUN_WINDOW_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define GRWD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("grwd assertion failed");
`define GRWD_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> prop) \
    else $error("grwd assertion failed");
`else
`define GRWD_ASSERT(label, clk, rst_n, prop)
`define GRWD_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

@@ rtl/grwd_pkg.sv @@
package grwd_pkg;

  localparam int WindowBits = 16;
  localparam int NumCells   = 16;
  localparam int PosW       = 5;
  localparam int LenW       = 6;
  localparam int SumW       = 8;

  typedef struct packed {
    logic [WindowBits-1:0] window;
    logic [PosW-1:0]       pos;
    logic [PosW-1:0]       count;
    logic [SumW-1:0]       sum;
    logic [SumW-1:0]       odd_sum;
    logic                  done;
  } cell_state_t;

endpackage

@@ rtl/grwd_cell.sv @@
`include "gamma_run_window_decoder_defines.svh"

module grwd_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                prev_valid,
  input  grwd_pkg::cell_state_t prev_state,
  output logic                valid_r,
  output grwd_pkg::cell_state_t state_r
);
  import grwd_pkg::*;

  logic [WindowBits-1:0] aligned;
  logic [PosW-1:0]       zeros;
  logic [LenW-1:0]       len;
  logic [PosW-1:0]       remaining;
  logic [LenW-1:0]       shamt;
  logic [SumW-1:0]       value;
  logic                  fits;
  cell_state_t           state_nxt;

  // highest set bit wins, no set bit gives sixteen zeros
  function automatic logic [PosW-1:0] lead_zeros(input logic [WindowBits-1:0] v);
    logic [PosW-1:0] z;
    z = PosW'(WindowBits);
    for (int i = 0; i < WindowBits; i++) begin
      if (v[i]) begin
        z = PosW'(WindowBits - 1 - i);
      end
    end
    return z;
  endfunction

  always_comb begin
    aligned   = prev_state.window << prev_state.pos;
    zeros     = lead_zeros(aligned);
    len       = {zeros, 1'b1};
    remaining = PosW'(WindowBits) - prev_state.pos;
    fits      = !prev_state.done && (len <= {1'b0, remaining});
    shamt     = LenW'(WindowBits) - len;
    value     = SumW'(aligned >> shamt[PosW-1:0]);

    state_nxt = prev_state;
    if (fits) begin
      state_nxt.pos   = prev_state.pos + len[PosW-1:0];
      state_nxt.count = prev_state.count + PosW'(1);
      state_nxt.sum   = prev_state.sum + value;
      // count before this code is even, so this one is odd-numbered
      if (!prev_state.count[0]) begin
        state_nxt.odd_sum = prev_state.odd_sum + value;
      end
    end else begin
      state_nxt.done = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      state_r <= state_nxt;
    end
  end

  `GRWD_ASSERT(a_pos_in_window, clk, rst_n, valid_r |-> (state_r.pos <= PosW'(WindowBits)))
  `GRWD_ASSERT(a_count_le_pos, clk, rst_n, valid_r |-> (state_r.count <= state_r.pos))
  `GRWD_ASSERT_NEXT(a_done_sticky, clk, rst_n, adv && prev_valid && prev_state.done, state_r.done)
  `GRWD_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, !adv, $stable(valid_r) && $stable(state_r))

endmodule

@@ rtl/gamma_run_window_decoder.sv @@
// an accepted window moves through the cell registers in order to its result word on the out_ ports
// throughput: one window per cycle unless the output stalls; the chain of 16 decode cells advances as one
// each cell decodes at most one gamma code, the last cell's register is the output word
// the whole chain holds while a finished word is stalled at the output
// reset: synchronous active-low rst_n clears the cell valid bits, payload is not reset
module gamma_run_window_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [grwd_pkg::WindowBits-1:0] in_window,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [grwd_pkg::PosW-1:0]     out_run_count,
  output logic [grwd_pkg::PosW-1:0]     out_bits_used,
  output logic [grwd_pkg::SumW-1:0]     out_value_sum,
  output logic [grwd_pkg::SumW-1:0]     out_odd_run_sum
);
  import grwd_pkg::*;

  logic        adv;
  logic        valid_chain [NumCells+1];
  cell_state_t state_chain [NumCells+1];

  assign adv      = !(valid_chain[NumCells] && out_stall);
  assign in_stall = !adv;

  always_comb begin
    valid_chain[0]         = in_valid;
    state_chain[0]         = '0;
    state_chain[0].window  = in_window;
  end

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    grwd_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .prev_valid (valid_chain[g]),
      .prev_state (state_chain[g]),
      .valid_r    (valid_chain[g+1]),
      .state_r    (state_chain[g+1])
    );
  end

  assign out_valid       = valid_chain[NumCells];
  assign out_run_count   = state_chain[NumCells].count;
  assign out_bits_used   = state_chain[NumCells].pos;
  assign out_value_sum   = state_chain[NumCells].sum;
  assign out_odd_run_sum = state_chain[NumCells].odd_sum;

endmodule

@@ tb/sv/gamma_run_window_decoder_tb.sv @@
module gamma_run_window_decoder_tb;

  import grwd_pkg::*;

  typedef struct packed {
    logic [PosW-1:0] run_count;
    logic [PosW-1:0] bits_used;
    logic [SumW-1:0] value_sum;
    logic [SumW-1:0] odd_run_sum;
  } decoded_word_t;

  typedef struct packed {
    logic [WindowBits-1:0] window;
    logic                  typed_in;
    decoded_word_t         word;
  } window_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [WindowBits-1:0] in_window;
  logic                  out_valid;
  logic                  out_stall;
  logic [PosW-1:0]       out_run_count;
  logic [PosW-1:0]       out_bits_used;
  logic [SumW-1:0]       out_value_sum;
  logic [SumW-1:0]       out_odd_run_sum;

  logic hold_req;
  logic recv_quiet;

  decoded_word_t expected_words [$];
  int            error_count = 0;

  // rows with typed_in set carry a hand-written word, the rest use the predictor
  window_row_t directed_rows [20] = '{
    '{16'h0000, 1'b1, '{5'd0,  5'd0,  8'd0,  8'd0}},
    '{16'hFFFF, 1'b1, '{5'd16, 5'd16, 8'd16, 8'd8}},
    '{16'h8000, 1'b1, '{5'd1,  5'd1,  8'd1,  8'd1}},
    '{16'h0001, 1'b1, '{5'd0,  5'd0,  8'd0,  8'd0}},
    '{16'h00FF, 1'b1, '{5'd0,  5'd0,  8'd0,  8'd0}},
    '{16'h0002, 1'b1, '{5'd0,  5'd0,  8'd0,  8'd0}},
    '{16'h01FF, 1'b0, '0},
    '{16'h0100, 1'b0, '0},
    '{16'h0080, 1'b0, '0},
    '{16'h4000, 1'b0, '0},
    '{16'h5555, 1'b0, '0},
    '{16'hAAAA, 1'b0, '0},
    '{16'h2492, 1'b0, '0},
    '{16'h9249, 1'b0, '0},
    '{16'h7FFF, 1'b0, '0},
    '{16'h8001, 1'b0, '0},
    '{16'h1234, 1'b0, '0},
    '{16'hFEDC, 1'b0, '0},
    '{16'h0003, 1'b0, '0},
    '{16'hC000, 1'b0, '0}
  };

  gamma_run_window_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_window       (in_window),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_run_count   (out_run_count),
    .out_bits_used   (out_bits_used),
    .out_value_sum   (out_value_sum),
    .out_odd_run_sum (out_odd_run_sum)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic decoded_word_t decode_window(logic [WindowBits-1:0] w);
    decoded_word_t         r;
    logic [WindowBits-1:0] aligned;
    logic [WindowBits-1:0] value;
    int                    pos;
    int                    z;
    int                    len;
    int                    count;
    r     = '0;
    pos   = 0;
    count = 0;
    while (pos < WindowBits) begin
      aligned = w << pos;
      z = 0;
      while (z < WindowBits - pos && !aligned[WindowBits-1-z]) z++;
      len = 2 * z + 1;
      // zeros or code body running off the end never complete
      if (z >= WindowBits - pos || len > WindowBits - pos) break;
      value = aligned >> (WindowBits - len);
      count++;
      r.value_sum = r.value_sum + value[SumW-1:0];
      if (count % 2 == 1) r.odd_run_sum = r.odd_run_sum + value[SumW-1:0];
      pos += len;
    end
    r.run_count = count[PosW-1:0];
    r.bits_used = pos[PosW-1:0];
    return r;
  endfunction

  // mostly zero, often short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_window(input logic [WindowBits-1:0] w, input decoded_word_t word);
    in_valid  <= 1'b1;
    in_window <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expected_words.push_back(word);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // receiver: checks each accepted word, then picks the stall for the next cycle
  initial begin
    int            stall_left;
    int            hold_left;
    bit            hold_taken;
    decoded_word_t want;
    stall_left = 0;
    hold_left  = 0;
    hold_taken = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_words.size() == 0) begin
          $display("%0t: word with no window pending, actual %0d %0d %0d %0d", $time,
                   out_run_count, out_bits_used, out_value_sum, out_odd_run_sum);
          error_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_run_count !== want.run_count) begin
            $display("%0t: run_count expected %0d actual %0d", $time,
                     want.run_count, out_run_count);
            error_count++;
          end
          if (out_bits_used !== want.bits_used) begin
            $display("%0t: bits_used expected %0d actual %0d", $time,
                     want.bits_used, out_bits_used);
            error_count++;
          end
          if (out_value_sum !== want.value_sum) begin
            $display("%0t: value_sum expected %0d actual %0d", $time,
                     want.value_sum, out_value_sum);
            error_count++;
          end
          if (out_odd_run_sum !== want.odd_run_sum) begin
            $display("%0t: odd_run_sum expected %0d actual %0d", $time,
                     want.odd_run_sum, out_odd_run_sum);
            error_count++;
          end
        end
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1;
        hold_left  = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_quiet) begin
        out_stall <= 1'b0;
      end else begin
        if (stall_left == 0) stall_left = idle_len();
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    logic [WindowBits-1:0] w;
    int                    pos;
    int                    z;
    int                    len;
    int                    drain;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_window  = '0;
    hold_req   = 1'b0;
    recv_quiet = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      idle_sender(idle_len());
      send_window(directed_rows[i].window,
                  directed_rows[i].typed_in ? directed_rows[i].word
                                            : decode_window(directed_rows[i].window));
    end

    // phase 0 runs flat out, phase 3 fills the pipe behind a long hold,
    // phase 5 starts from an empty pipe
    for (int phase = 0; phase < 7; phase++) begin
      recv_quiet <= (phase == 0);
      hold_req   <= (phase == 3);
      if (phase == 5) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_words.size() != 0);
      end
      for (int n = 0; n < 200; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          w = 16'($urandom_range(0, 16'hFFFF));
        end else begin
          // chain of well-formed codes, mostly short, ending in zeros or noise
          w   = '0;
          pos = 0;
          while (pos < WindowBits) begin
            z   = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(3, 7);
            len = 2 * z + 1;
            if (pos + len > WindowBits) begin
              if ($urandom_range(0, 1) == 1)
                w = w | 16'($urandom_range(0, (1 << (WindowBits - pos)) - 1));
              break;
            end
            w = w | 16'(((1 << z) | $urandom_range(0, (1 << z) - 1))
                        << (WindowBits - pos - len));
            pos += len;
          end
        end
        if (phase != 0 && phase != 3) idle_sender(idle_len());
        send_window(w, decode_window(w));
      end
    end

    in_valid <= 1'b0;
    drain = 0;
    while (expected_words.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);
    if (expected_words.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, expected_words.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/grwd_pkg.sv
rtl/grwd_cell.sv
rtl/gamma_run_window_decoder.sv
tb/sv/gamma_run_window_decoder_tb.sv
